[design/byte_frequency_min_heap_builder_macros.svh]
// ----------------------------------------------------------------------------
// Byte frequency min-heap builder assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_FREQUENCY_MIN_HEAP_BUILDER_MACROS_SVH
`define BYTE_FREQUENCY_MIN_HEAP_BUILDER_MACROS_SVH

// Condition holds at every edge out of reset
`define BFMH_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define BFMH_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BFMH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bfmh_pkg.sv]
// ----------------------------------------------------------------------------
// bfmh_pkg
// Shared types and constants of the byte frequency min-heap builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfmh_pkg;

   // Fixed field widths of the request and response words
   localparam int BYTE_W     = 8;
   localparam int TALLY_W    = 9;
   localparam int FREQ_OUT_W = 32;

   // Action codes of a request word
   typedef enum logic [1:0] {
      ACT_COUNT = 2'd0,
      ACT_BUILD = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } bfmh_action_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_REPLY,
      ST_SCAN_CHK,
      ST_SIFT
   } bfmh_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;      // latch request word, launch memory reads
      logic count_wr;    // update histogram entry and distinct count
      logic emit;        // load the response register
      logic build_init;  // empty the heap, start scan at symbol zero
      logic push_start;  // load scanned symbol as the entry to insert
      logic sift_step;   // one compare/move step of the insert
      logic scan_next;   // advance scan, read next histogram entry
   } bfmh_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;    // response register can take a word this cycle
      logic scan_hit;    // scanned symbol has a nonzero count
      logic scan_last;   // scan sits on the last symbol
      logic sift_done;   // insert ends at the current slot
   } bfmh_status_type;

endpackage

[design/bfmh_ctrl.sv]
// ----------------------------------------------------------------------------
// bfmh_ctrl
// Sequencer for count, build and read actions of the heap builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_frequency_min_heap_builder_macros.svh"

module bfmh_ctrl
   import bfmh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_action,
   input  bfmh_status_type status,
   output bfmh_cmd_type    cmd
);

   bfmh_state_type  state_ff;
   bfmh_state_type  state_in;
   bfmh_action_type action;

   assign action = bfmh_action_type'(req_action);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (action)
                  ACT_COUNT: state_in = ST_COUNT;
                  ACT_BUILD: state_in = ST_SCAN_CHK;
                  default:   state_in = ST_REPLY;
               endcase
            end
         end
         ST_COUNT, ST_REPLY: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_CHK: begin
            if (status.scan_hit) begin
               state_in = ST_SIFT;
            end else if (status.scan_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_SIFT: begin
            if (status.sift_done) begin
               state_in = status.scan_last ? ST_REPLY : ST_SCAN_CHK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            cmd.build_init = req_valid && (action == ACT_BUILD);
         end
         ST_COUNT: begin
            cmd.count_wr = status.out_free;
            cmd.emit     = status.out_free;
         end
         ST_REPLY: begin
            cmd.emit = status.out_free;
         end
         ST_SCAN_CHK: begin
            cmd.push_start = status.scan_hit;
            cmd.scan_next  = !status.scan_hit && !status.scan_last;
         end
         ST_SIFT: begin
            cmd.sift_step = 1'b1;
            cmd.scan_next = status.sift_done && !status.scan_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Checks
   `BFMH_ASSERT_IMPL(a_accept_idle, cmd.accept, state_ff == ST_IDLE, "accept outside idle")
   `BFMH_ASSERT(a_cmd_excl, $onehot0({cmd.build_init, cmd.push_start, cmd.scan_next, cmd.count_wr}), "conflicting datapath commands")
   `BFMH_ASSERT_NEXT(a_push_sift, cmd.push_start, state_ff == ST_SIFT, "insert did not enter sift")

endmodule

[design/bfmh_dp.sv]
// ----------------------------------------------------------------------------
// bfmh_dp
// Histogram memory, heap memory, insert datapath and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_frequency_min_heap_builder_macros.svh"

module bfmh_dp
   import bfmh_pkg::*;
#(
   parameter int SYMBOLS    = 256,
   parameter int FREQ_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  bfmh_cmd_type          cmd,
   output bfmh_status_type       status,
   input  logic [1:0]            req_action,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic [BYTE_W-1:0]     req_read_index,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [BYTE_W-1:0]     rsp_symbol,
   output logic [FREQ_OUT_W-1:0] rsp_frequency,
   output logic [TALLY_W-1:0]    rsp_tally,
   output logic                  rsp_slot_valid
);

   localparam int                    AW        = $clog2(SYMBOLS);
   localparam logic [TALLY_W-1:0]    SYM_LIMIT = TALLY_W'(SYMBOLS);
   localparam logic [AW-1:0]         SYM_LAST  = AW'(SYMBOLS - 1);
   localparam logic [FREQ_WIDTH-1:0] FREQ_MAX  = '1;

   function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
      return (p - AW'(1)) >> 1;
   endfunction

   // Memories
   logic [FREQ_WIDTH-1:0] freq_mem [SYMBOLS];
   logic                  fvalid_ff [SYMBOLS];
   logic [AW-1:0]         heap_sym_mem [SYMBOLS];
   logic [FREQ_WIDTH-1:0] heap_freq_mem [SYMBOLS];

   // Request word
   bfmh_action_type       action_ff;
   logic [BYTE_W-1:0]     byte_ff;
   logic [BYTE_W-1:0]     index_ff;

   // Read data
   logic [FREQ_WIDTH-1:0] freq_rd_ff;
   logic                  fval_rd_ff;
   logic [AW-1:0]         heap_sym_rd_ff;
   logic [FREQ_WIDTH-1:0] heap_freq_rd_ff;

   // Build state
   logic [TALLY_W-1:0]    distinct_ff,  distinct_in;
   logic [TALLY_W-1:0]    heap_size_ff, heap_size_in;
   logic [AW-1:0]         scan_idx_ff,  scan_idx_in;
   logic [AW-1:0]         pos_ff,       pos_in;
   logic [AW-1:0]         cur_sym_ff;
   logic [FREQ_WIDTH-1:0] cur_freq_ff;

   // Response register
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic [FREQ_OUT_W-1:0] rsp_freq_ff,   rsp_freq_in;
   logic [TALLY_W-1:0]    rsp_tally_ff,  rsp_tally_in;
   logic                  rsp_slot_ff,   rsp_slot_in;

   // Combinational controls
   logic [FREQ_WIDTH-1:0] freq_cur;
   logic                  byte_ok;
   logic                  freq_wr_en;
   logic [AW-1:0]         byte_addr;
   logic                  freq_rd_en;
   logic [AW-1:0]         freq_rd_addr;
   logic                  sift_done;
   logic                  heap_rd_en;
   logic [AW-1:0]         heap_rd_addr;
   logic [AW-1:0]         heap_wr_sym;
   logic [FREQ_WIDTH-1:0] heap_wr_freq;
   logic                  rd_hit;

   // Latch request word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= bfmh_action_type'(req_action);
         byte_ff   <= req_byte_value;
         index_ff  <= req_read_index;
      end
   end

   // Histogram count update
   assign byte_addr  = byte_ff[AW-1:0];
   assign freq_cur   = fval_rd_ff ? freq_rd_ff : '0;
   assign byte_ok    = {1'b0, byte_ff} < SYM_LIMIT;
   assign freq_wr_en = cmd.count_wr && byte_ok && (freq_cur != FREQ_MAX);

   always_comb begin
      distinct_in = distinct_ff;
      if (cmd.count_wr && byte_ok && (freq_cur == '0)) begin
         distinct_in = distinct_ff + TALLY_W'(1);
      end
   end

   // Scan index and histogram read port
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.build_init) begin
         scan_idx_in = '0;
      end else if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + AW'(1);
      end
   end

   assign freq_rd_en   = cmd.accept || cmd.scan_next;
   assign freq_rd_addr = (cmd.accept && !cmd.build_init) ? req_byte_value[AW-1:0]
                                                         : scan_idx_in;

   always_ff @(posedge clock) begin
      if (freq_wr_en) begin
         freq_mem[byte_addr] <= freq_cur + FREQ_WIDTH'(1);
      end
      if (freq_rd_en) begin
         freq_rd_ff <= freq_mem[freq_rd_addr];
      end
   end

   // Entry valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOLS; i++) begin
            fvalid_ff[i] <= 1'b0;
         end
         fval_rd_ff <= 1'b0;
      end else begin
         if (freq_wr_en) begin
            fvalid_ff[byte_addr] <= 1'b1;
         end
         if (freq_rd_en) begin
            fval_rd_ff <= fvalid_ff[freq_rd_addr];
         end
      end
   end

   // Insert: hole moves up while the new entry is strictly smaller
   assign sift_done = (pos_ff == '0) || !(cur_freq_ff < heap_freq_rd_ff);

   always_comb begin
      pos_in = pos_ff;
      if (cmd.push_start) begin
         pos_in = heap_size_ff[AW-1:0];
      end else if (cmd.sift_step && !sift_done) begin
         pos_in = parent_of(pos_ff);
      end
   end

   always_comb begin
      heap_size_in = heap_size_ff;
      if (cmd.build_init) begin
         heap_size_in = '0;
      end else if (cmd.push_start) begin
         heap_size_in = heap_size_ff + TALLY_W'(1);
      end
   end

   assign heap_rd_en   = cmd.accept || cmd.push_start || (cmd.sift_step && !sift_done);
   assign heap_rd_addr = cmd.accept ? req_read_index[AW-1:0] : parent_of(pos_in);
   assign heap_wr_sym  = sift_done ? cur_sym_ff  : heap_sym_rd_ff;
   assign heap_wr_freq = sift_done ? cur_freq_ff : heap_freq_rd_ff;

   // Heap memory: one write and one read port
   always_ff @(posedge clock) begin
      if (cmd.sift_step) begin
         heap_sym_mem[pos_ff]  <= heap_wr_sym;
         heap_freq_mem[pos_ff] <= heap_wr_freq;
      end
      if (heap_rd_en) begin
         heap_sym_rd_ff  <= heap_sym_mem[heap_rd_addr];
         heap_freq_rd_ff <= heap_freq_mem[heap_rd_addr];
      end
   end

   // Entry being inserted
   always_ff @(posedge clock) begin
      if (cmd.push_start) begin
         cur_sym_ff  <= scan_idx_ff;
         cur_freq_ff <= freq_cur;
      end
      pos_ff <= pos_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff  <= '0;
         heap_size_ff <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         distinct_ff  <= distinct_in;
         heap_size_ff <= heap_size_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response word
   assign rd_hit = (action_ff == ACT_READ) && ({1'b0, index_ff} < heap_size_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in = '0;
      rsp_freq_in   = '0;
      rsp_slot_in   = rd_hit;
      rsp_tally_in  = (action_ff == ACT_COUNT) ? distinct_in : heap_size_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
      if (rd_hit) begin
         rsp_symbol_in = BYTE_W'(heap_sym_rd_ff);
         rsp_freq_in   = FREQ_OUT_W'(heap_freq_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_symbol_ff <= rsp_symbol_in;
         rsp_freq_ff   <= rsp_freq_in;
         rsp_tally_ff  <= rsp_tally_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol     = rsp_symbol_ff;
   assign rsp_frequency  = rsp_freq_ff;
   assign rsp_tally      = rsp_tally_ff;
   assign rsp_slot_valid = rsp_slot_ff;

   // Status to controller
   always_comb begin
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.scan_hit  = fval_rd_ff && (freq_rd_ff != '0);
      status.scan_last = scan_idx_ff == SYM_LAST;
      status.sift_done = sift_done;
   end

   // Checks
   `BFMH_ASSERT_IMPL(a_emit_free, cmd.emit, status.out_free, "response overwritten while stalled")
   `BFMH_ASSERT(a_heap_bound, heap_size_ff <= SYM_LIMIT, "heap size beyond alphabet")
   `BFMH_ASSERT_IMPL(a_slot_size, rsp_valid_ff && rsp_slot_ff, rsp_tally_ff != '0, "valid slot from an empty heap")

endmodule

[design/byte_frequency_min_heap_builder.sv]
// Count and read: accept latches the request word and launches the memory read; the
// response word is registered once the response register is free. Build scans every
// symbol in turn and inserts each nonzero count, sifting it up until it settles.
// One action is in flight at a time; a new word is taken once the response is registered.
// Reset clears the histogram valid bits, distinct count and heap size;
// no clearing pass, heap contents are undefined until the first build.
// ----------------------------------------------------------------------------
// byte_frequency_min_heap_builder
// Byte histogram with a binary min-heap built from the nonzero counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_frequency_min_heap_builder
   import bfmh_pkg::*;
#(
   parameter int SYMBOLS    = 256,
   parameter int FREQ_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic [BYTE_W-1:0]     req_read_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_symbol,
   output logic [FREQ_OUT_W-1:0] rsp_frequency,
   output logic [TALLY_W-1:0]    rsp_tally,
   output logic                  rsp_slot_valid
);

   bfmh_cmd_type    cmd;
   bfmh_status_type status;

   // Sequencer
   bfmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   // Memories and datapath
   bfmh_dp #(
      .SYMBOLS    (SYMBOLS),
      .FREQ_WIDTH (FREQ_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .req_read_index (req_read_index),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_symbol     (rsp_symbol),
      .rsp_frequency  (rsp_frequency),
      .rsp_tally      (rsp_tally),
      .rsp_slot_valid (rsp_slot_valid)
   );

endmodule
